[sv/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Types, codes and defaults shared by the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // default table geometry
  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  // configuration port geometry
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  // blocks_in_use after reset
  localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIT_POLICY    = 2'd0,
    REG_BLOCKS_IN_USE = 2'd1
  } fpba_reg_t;

  // placement policies
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fpba_policy_t;

  // request kinds
  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_ALLOCATE = 1'b1
  } fpba_action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2
  } fpba_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WRAP = 2'd1,
    S_SCAN = 2'd2,
    S_OUT  = 2'd3
  } fpba_state_t;

  // input transaction payload
  typedef struct packed {
    logic        action;
    logic [3:0]  load_index;
    logic [15:0] size_value;
  } fpba_in_t;

  // result transaction payload
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_index;
    logic [15:0] remaining_free;
  } fpba_out_t;

endpackage

[sv/fit_policy_block_allocator.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-size table with first, next, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction loads a block's free size or asks for an
//           allocation; in_ready is high only while the sequencer is idle.
//   out_* : one result transaction per input (status, index, free size left),
//           held in an output register until the receiver takes it.
//   cfg_* : write-only registers, fit_policy and blocks_in_use, written idle.
// Timing:
//   a load, or an allocation with no blocks in use, goes from acceptance
//   straight to the result register; any other allocation first scans the
//   n active entries, and next fit first reduces a start pointer at or above
//   n by repeated subtraction of n until it is below n. The scan is done by
//   the shared compare/subtract unit, one table entry per cycle.
// Reset:
//   every entry reads as zero (valid bits cleared), pointer, control and
//   configuration registers return to their defaults; no clearing pass is needed.
// Stall:
//   a finished result waits in a holding register while the output register
//   is full; the next input is taken as soon as that result has moved on.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
  parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpba_pkg::fpba_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpba_pkg::fpba_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [fpba_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fpba_pkg::*;

  localparam int IDX_W = $clog2(BLOCKS);
  localparam int CNT_W = $clog2(BLOCKS + 1);

  // control and datapath registers
  fpba_state_t            state_r, state_nxt;
  fpba_policy_t           policy_r;
  logic [4:0]             bu_r;
  logic [SIZE_BITS-1:0]   req_size_r, req_size_nxt;
  logic [IDX_W-1:0]       next_start_r, next_start_nxt;
  logic [IDX_W-1:0]       addr_r, addr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [SIZE_BITS-1:0]   rd_data_r;
  logic                   rd_ent_vld_r;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]   best_r, best_nxt;
  fpba_out_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  fpba_out_t              out_data_r, out_data_nxt;
  logic [BLOCKS-1:0]      vld_r;

  // table storage and write port
  logic [SIZE_BITS-1:0]   mem [BLOCKS];
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [SIZE_BITS-1:0]   wr_data;

  // decoded values
  logic [CNT_W-1:0]       n_act;
  logic [SIZE_BITS-1:0]   size_in;
  logic                   load_in_range;
  logic                   in_xact;
  logic                   out_free;
  logic                   issue;
  logic                   scan_done;
  logic                   wrap_sub;
  logic [SIZE_BITS-1:0]   rd_free;
  logic [SIZE_BITS:0]     diff;
  logic                   fits;
  logic [SIZE_BITS-1:0]   left;
  logic                   take;

  // active entry count, clamped to the table
  always_comb begin
    if (32'(bu_r) > 32'(BLOCKS)) begin
      n_act = CNT_W'(BLOCKS);
    end else begin
      n_act = CNT_W'(bu_r);
    end
  end

  assign size_in       = SIZE_BITS'(in_data.size_value);
  assign load_in_range = 32'(in_data.load_index) < 32'(BLOCKS);
  assign in_ready      = (state_r == S_IDLE);
  assign in_xact       = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign issue         = (cnt_r != n_act);
  assign scan_done     = !issue && !rd_pend_r;
  assign wrap_sub      = CNT_W'(addr_r) >= n_act;

  // shared compare/subtract unit on the entry just read
  assign rd_free = rd_ent_vld_r ? rd_data_r : '0;
  assign diff    = {1'b0, rd_free} - {1'b0, req_size_r};
  assign fits    = !diff[SIZE_BITS];
  assign left    = diff[SIZE_BITS-1:0];
  assign take    = rd_pend_r && fits &&
                   (!found_r ||
                    (policy_r == FIT_BEST  && left < best_r) ||
                    (policy_r == FIT_WORST && left > best_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          if (in_data.action == ACT_LOAD || n_act == '0) begin
            state_nxt = S_OUT;
          end else if (policy_r == FIT_NEXT) begin
            state_nxt = S_WRAP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_WRAP: begin
        if (!wrap_sub) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_size_nxt   = req_size_r;
    next_start_nxt = next_start_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = addr_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = pick_r;
    wr_data        = best_r;

    // result leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          if (in_data.action == ACT_LOAD) begin
            res_nxt.status       = ST_LOADED;
            res_nxt.chosen_index = in_data.load_index;
            if (load_in_range) begin
              wr_en                  = 1'b1;
              wr_addr                = IDX_W'(in_data.load_index);
              wr_data                = size_in;
              res_nxt.remaining_free = 16'(size_in);
            end else begin
              res_nxt.remaining_free = '0;
            end
          end else begin
            req_size_nxt = size_in;
            found_nxt    = 1'b0;
            cnt_nxt      = '0;
            addr_nxt     = (policy_r == FIT_NEXT) ? next_start_r : '0;
            res_nxt.status         = ST_NO_FIT;
            res_nxt.chosen_index   = '0;
            res_nxt.remaining_free = '0;
          end
        end
      end
      S_WRAP: begin
        // reduce the start pointer below the active count
        if (wrap_sub) begin
          addr_nxt = IDX_W'(CNT_W'(addr_r) - n_act);
        end
      end
      S_SCAN: begin
        // issue one read per cycle with wrap at the active count
        if (issue) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
          if (CNT_W'(addr_r) + CNT_W'(1) == n_act) begin
            addr_nxt = '0;
          end else begin
            addr_nxt = addr_r + IDX_W'(1);
          end
        end
        // keep the candidate under the current policy
        if (take) begin
          found_nxt = 1'b1;
          pick_nxt  = rd_idx_r;
          best_nxt  = left;
        end
        // write back the chosen entry, if any, and form the result
        if (scan_done) begin
          if (found_r) begin
            wr_en = 1'b1;
            if (policy_r == FIT_NEXT) begin
              next_start_nxt = pick_r;
            end
            res_nxt.status         = ST_ALLOCATED;
            res_nxt.chosen_index   = 4'(pick_r);
            res_nxt.remaining_free = 16'(best_r);
          end else begin
            res_nxt.status         = ST_NO_FIT;
            res_nxt.chosen_index   = '0;
            res_nxt.remaining_free = '0;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_start_r <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      found_r      <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      next_start_r <= next_start_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= rd_pend_nxt;
      found_r      <= found_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_size_r <= req_size_nxt;
    addr_r     <= addr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= FIT_FIRST;
      bu_r     <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      priority case (cfg_addr)
        REG_FIT_POLICY:    policy_r <= fpba_policy_t'(cfg_wdata[1:0]);
        REG_BLOCKS_IN_USE: bu_r     <= cfg_wdata[4:0];
        default:           bu_r     <= bu_r;
      endcase
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r    <= mem[addr_r];
    rd_ent_vld_r <= vld_r[addr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // a kept candidate always lies inside the searched range
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found_r) |-> (CNT_W'(pick_r) < n_act))
    else $error("candidate index outside active range");

  // the read counter never runs past the active count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= n_act))
    else $error("scan counter past active count");

  // start reduction only runs with a nonzero active count
  a_wrap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP) |-> (n_act != '0))
    else $error("start reduction with empty table");

  // a scan write-back only happens for a found block
  a_wb_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && wr_en) |-> (found_r && scan_done))
    else $error("write-back without a chosen block");

  // a result is never dropped while the output register is full
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT))
    else $error("pending result lost while output stalled");
`endif

endmodule
